// ----- design/bmhq_pkg.sv -----
// Package for the binary max-heap priority queue.
// Shared widths, codes, controller states and controller/datapath structs.
// No dependencies.
package bmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 7;
    localparam int STATUS_W     = 2;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DEL_RD,
        S_DEL_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic up_rd;
        logic up_cmp;
        logic del_rd;
        logic del_load;
        logic dn_cmp;
    } ctl_cmd_t;

    typedef struct packed {
        logic err;
        logic ins;
        logic pos_zero;
        logic up_move;
        logic dn_move;
    } dp_stat_t;

endpackage

// ----- design/binary_max_heap_queue_core.sv -----
// Binary max-heap priority queue, top level: bmhq_ctrl plus bmhq_dpath.
// Depends on bmhq_pkg.
// A transaction is taken when start is high and busy is low; its single
// result appears for one cycle with done high and cannot be stalled, so the
// receiver must capture it in that cycle. Each transaction runs alone over
// one heap memory with one write and two registered read ports: an insert
// alternates read and compare states for each level the key moves up, a
// delete-max reads the root and the last entry, loads them, then alternates
// compare and read states for each level the key moves down (at most
// log2(CAPACITY) levels either way), and an error goes straight to done.
// The heap memory needs no clearing after reset.
module binary_max_heap_queue_core
#(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   action,
    input  logic signed [bmhq_pkg::DATA_W-1:0]     value,
    output logic                                   done,
    output logic [bmhq_pkg::STATUS_W-1:0]          status,
    output logic signed [bmhq_pkg::DATA_W-1:0]     result_value,
    output logic [bmhq_pkg::COUNT_OUT_W-1:0]       entry_count_after
);

    bmhq_pkg::ctl_cmd_t cmd;
    bmhq_pkg::dp_stat_t stat;

    bmhq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bmhq_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .action            (action),
        .value             (value),
        .stat              (stat),
        .status            (status),
        .result_value      (result_value),
        .entry_count_after (entry_count_after)
    );

endmodule

// ----- design/bmhq_ctrl.sv -----
// Controller state machine for the binary max-heap priority queue.
// Sequences insert sift-up and delete sift-down; depends on bmhq_pkg.
module bmhq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bmhq_pkg::dp_stat_t stat,
    output bmhq_pkg::ctl_cmd_t cmd,
    output logic              busy,
    output logic              done
);

    bmhq_pkg::state_t state_reg;
    bmhq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmhq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    priority if (stat.err)
                        state_next = bmhq_pkg::S_DONE;
                    else if (stat.ins)
                        state_next = bmhq_pkg::S_UP_RD;
                    else
                        state_next = bmhq_pkg::S_DEL_RD;
                end
            end
            bmhq_pkg::S_UP_RD:
            begin
                state_next = stat.pos_zero ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
            end
            bmhq_pkg::S_UP_CMP:
            begin
                state_next = stat.up_move ? bmhq_pkg::S_UP_RD : bmhq_pkg::S_DONE;
            end
            bmhq_pkg::S_DEL_RD:   state_next = bmhq_pkg::S_DEL_LOAD;
            bmhq_pkg::S_DEL_LOAD: state_next = bmhq_pkg::S_DN_CMP;
            bmhq_pkg::S_DN_RD:    state_next = bmhq_pkg::S_DN_CMP;
            bmhq_pkg::S_DN_CMP:
            begin
                state_next = stat.dn_move ? bmhq_pkg::S_DN_RD : bmhq_pkg::S_DONE;
            end
            bmhq_pkg::S_DONE:     state_next = bmhq_pkg::S_IDLE;
            default:              state_next = bmhq_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.accept   = (state_reg == bmhq_pkg::S_IDLE) && start;
        cmd.up_rd    = (state_reg == bmhq_pkg::S_UP_RD);
        cmd.up_cmp   = (state_reg == bmhq_pkg::S_UP_CMP);
        cmd.del_rd   = (state_reg == bmhq_pkg::S_DEL_RD);
        cmd.del_load = (state_reg == bmhq_pkg::S_DEL_LOAD);
        cmd.dn_cmp   = (state_reg == bmhq_pkg::S_DN_CMP);
        busy         = (state_reg != bmhq_pkg::S_IDLE);
        done         = (state_reg == bmhq_pkg::S_DONE);
    end

endmodule

// ----- design/bmhq_dpath.sv -----
// Datapath for the binary max-heap priority queue: heap memory, hole
// position, moving key, entry count and result registers. Depends on bmhq_pkg.
module bmhq_dpath
#(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  bmhq_pkg::ctl_cmd_t                     cmd,
    input  logic                                   action,
    input  logic signed [bmhq_pkg::DATA_W-1:0]     value,
    output bmhq_pkg::dp_stat_t                     stat,
    output logic [bmhq_pkg::STATUS_W-1:0]          status,
    output logic signed [bmhq_pkg::DATA_W-1:0]     result_value,
    output logic [bmhq_pkg::COUNT_OUT_W-1:0]       entry_count_after
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    logic signed [bmhq_pkg::DATA_W-1:0] heap_mem [CAPACITY];

    logic signed [bmhq_pkg::DATA_W-1:0] rd_a_reg;
    logic signed [bmhq_pkg::DATA_W-1:0] rd_b_reg;
    logic signed [bmhq_pkg::DATA_W-1:0] key_reg;
    logic signed [bmhq_pkg::DATA_W-1:0] key_next;
    logic signed [bmhq_pkg::DATA_W-1:0] res_reg;
    logic signed [bmhq_pkg::DATA_W-1:0] res_next;
    bmhq_pkg::status_t                  status_reg;
    bmhq_pkg::status_t                  status_next;
    logic [AW-1:0]                      pos_reg;
    logic [AW-1:0]                      pos_next;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;

    logic [AW-1:0]                      parent;
    logic [XW-1:0]                      left_w;
    logic [XW-1:0]                      right_w;
    logic [XW-1:0]                      count_x;
    logic                               l_gt;
    logic                               r_gt;
    logic signed [bmhq_pkg::DATA_W-1:0] best_val;
    logic                               full;
    logic                               empty;

    logic [AW-1:0]                      ra_addr;
    logic [AW-1:0]                      rb_addr;
    logic                               we;
    logic signed [bmhq_pkg::DATA_W-1:0] wdata;

    assign parent   = (pos_reg - AW'(1)) >> 1;
    assign left_w   = {1'b0, pos_reg, 1'b1};
    assign right_w  = {1'b0, pos_reg, 1'b0} + XW'(2);
    assign count_x  = XW'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    assign l_gt     = (left_w < count_x) && (rd_a_reg > key_reg);
    assign best_val = l_gt ? rd_a_reg : key_reg;
    assign r_gt     = (right_w < count_x) && (rd_b_reg > best_val);

    always_comb
    begin
        stat          = '0;
        stat.ins      = (action == bmhq_pkg::ACT_INSERT);
        stat.err      = stat.ins ? full : empty;
        stat.pos_zero = (pos_reg == '0);
        stat.up_move  = (key_reg > rd_a_reg);
        stat.dn_move  = l_gt || r_gt;
    end

    always_comb
    begin
        priority if (cmd.del_rd)
        begin
            ra_addr = '0;
            rb_addr = AW'(count_reg);
        end
        else if (cmd.up_rd)
        begin
            ra_addr = parent;
            rb_addr = right_w[AW-1:0];
        end
        else
        begin
            ra_addr = left_w[AW-1:0];
            rb_addr = right_w[AW-1:0];
        end
    end

    always_comb
    begin
        key_next    = key_reg;
        res_next    = res_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        we          = 1'b0;
        wdata       = key_reg;
        priority if (cmd.accept)
        begin
            if (action == bmhq_pkg::ACT_INSERT)
            begin
                if (full)
                begin
                    status_next = bmhq_pkg::ST_OVERFLOW;
                    res_next    = '0;
                end
                else
                begin
                    status_next = bmhq_pkg::ST_OK;
                    res_next    = value;
                    key_next    = value;
                    pos_next    = AW'(count_reg);
                    count_next  = count_reg + CW'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = bmhq_pkg::ST_UNDERFLOW;
                    res_next    = '0;
                end
                else
                begin
                    status_next = bmhq_pkg::ST_OK;
                    pos_next    = '0;
                    count_next  = count_reg - CW'(1);
                end
            end
        end
        else if (cmd.up_rd)
        begin
            we = (pos_reg == '0);
        end
        else if (cmd.up_cmp)
        begin
            we = 1'b1;
            if (stat.up_move)
            begin
                wdata    = rd_a_reg;
                pos_next = parent;
            end
        end
        else if (cmd.del_load)
        begin
            res_next = rd_a_reg;
            key_next = rd_b_reg;
        end
        else if (cmd.dn_cmp)
        begin
            we = 1'b1;
            if (r_gt)
            begin
                wdata    = rd_b_reg;
                pos_next = right_w[AW-1:0];
            end
            else if (l_gt)
            begin
                wdata    = rd_a_reg;
                pos_next = left_w[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            heap_mem[pos_reg] <= wdata;
        end
        rd_a_reg <= heap_mem[ra_addr];
        rd_b_reg <= heap_mem[rb_addr];
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign status            = status_reg;
    assign result_value      = res_reg;
    assign entry_count_after = bmhq_pkg::COUNT_OUT_W'(count_reg);

endmodule

// ----- design/bmhq_checker.sv -----
// Port-level checker for binary_max_heap_queue_core, attached by bind.
// Depends on bmhq_pkg.
module bmhq_checker
#(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
)
(
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic                                   busy,
    input logic                                   done,
    input logic [bmhq_pkg::STATUS_W-1:0]          status,
    input logic signed [bmhq_pkg::DATA_W-1:0]     result_value,
    input logic [bmhq_pkg::COUNT_OUT_W-1:0]       entry_count_after
);

    localparam logic [bmhq_pkg::COUNT_OUT_W-1:0] FULL_CNT =
        bmhq_pkg::COUNT_OUT_W'(CAPACITY);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("transaction accepted but busy not raised");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != bmhq_pkg::ST_OK) |-> result_value == '0)
        else $error("nonzero result on error");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == bmhq_pkg::ST_OVERFLOW) |-> entry_count_after == FULL_CNT)
        else $error("overflow reported while not full");

    a_unf_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == bmhq_pkg::ST_UNDERFLOW) |-> entry_count_after == '0)
        else $error("underflow reported while not empty");

endmodule

bind binary_max_heap_queue_core bmhq_checker
#(
    .CAPACITY (CAPACITY)
)
u_bmhq_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .status            (status),
    .result_value      (result_value),
    .entry_count_after (entry_count_after)
);
